// ===== rtl/spe_pkg.sv =====
`timescale 1ns / 1ps
// Package for the splitmix entropy pool: item kinds, step constants and
// the status struct between the top level and the mixer. No dependencies.
package spe_pkg;

  // Item kinds carried in the kind field
  typedef enum logic [2:0] {
    KindSeed    = 3'd0,
    KindWord    = 3'd1,
    KindByte    = 3'd2,
    KindEnd     = 3'd3,
    KindSqueeze = 3'd4
  } spe_kind_e;

  localparam logic [63:0] GoldenGamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MulOne      = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MulTwo      = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned ShiftOne   = 30;
  localparam int unsigned ShiftTwo   = 27;
  localparam int unsigned ShiftThree = 31;

  localparam logic [2:0] LaneLast = 3'd7;
  localparam logic [3:0] ByteMax  = 4'd8;

  // Mixer status seen by the top level
  typedef struct packed {
    logic busy;  // started and result not yet taken
    logic done;  // result word is held and valid
  } spe_mix_stat_t;

endpackage

// ===== rtl/spe_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the splitmix entropy pool.
// Input items carry kind and value; result items carry the output word.
interface spe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface spe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;
  logic [3:0]  byte_count;
  logic        last;

  modport source (output valid, output random_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input random_word, input byte_count, input last,
                  output ready);
endinterface

// ===== rtl/spe_mul32.sv =====
`timescale 1ns / 1ps
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// Used by spe_mixer for the partial products of the 64-bit multiplies.
module spe_mul32 (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // Registered product
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/spe_mixer.sv =====
`timescale 1ns / 1ps
// SplitMix64 output finalizer: xor-shift / multiply rounds over a shared
// 32x32 multiplier (spe_mul32). Depends on spe_pkg.
module spe_mixer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [63:0]           pool_i,
  input  logic                  ack_i,
  output spe_pkg::spe_mix_stat_t stat_o,
  output logic [63:0]           word_o
);
  import spe_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StMulLL,
    StMulLH,
    StMulHL,
    StMulFin,
    StHold
  } state_e;

  state_e      state_q;
  logic        round_q;
  logic [63:0] z_q;
  logic [63:0] acc_q;
  logic [63:0] word_q;

  logic [63:0] mconst;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] fin_hi;
  logic [63:0] fin_r;

  assign mconst = round_q ? MulTwo : MulOne;

  // Operand select for the partial products; low 64 bits of z*m only
  always_comb begin
    unique case (state_q)
      StMulLH: begin
        mul_a = z_q[31:0];
        mul_b = mconst[63:32];
      end
      StMulHL: begin
        mul_a = z_q[63:32];
        mul_b = mconst[31:0];
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mconst[31:0];
      end
    endcase
  end

  spe_mul32 u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Last cross term folds into the upper half
  assign fin_hi = acc_q[63:32] + prod[31:0];
  assign fin_r  = {fin_hi, acc_q[31:0]};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= 1'b0;
      z_q     <= '0;
      acc_q   <= '0;
      word_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            z_q     <= pool_i ^ (pool_i >> ShiftOne);
            round_q <= 1'b0;
            state_q <= StMulLL;
          end
        end
        StMulLL: state_q <= StMulLH;
        StMulLH: begin
          acc_q   <= prod;  // low x low
          state_q <= StMulHL;
        end
        StMulHL: begin
          acc_q[63:32] <= acc_q[63:32] + prod[31:0];  // low x high
          state_q      <= StMulFin;
        end
        StMulFin: begin
          if (!round_q) begin
            z_q     <= fin_r ^ (fin_r >> ShiftTwo);
            round_q <= 1'b1;
            state_q <= StMulLL;
          end else begin
            word_q  <= fin_r ^ (fin_r >> ShiftThree);
            state_q <= StHold;
          end
        end
        StHold: begin
          if (ack_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign stat_o.busy = (state_q != StIdle);
  assign stat_o.done = (state_q == StHold);
  assign word_o      = word_q;

endmodule

// ===== rtl/splitmix_entropy_pool.sv =====
`timescale 1ns / 1ps
// Splitmix entropy pool top level. Seed, mix and end items do not close the input.
// A squeeze item runs two 64-bit multiplies, each as partial products on the shared
// 32x32 multiplier, then moves into the output register, which waits while that
// register is full; the input reopens only after that, so squeezes never overlap.
// Asynchronous active-low reset clears pool, byte lane and all valids.
// Depends on spe_pkg, spe_if, spe_mixer.
module splitmix_entropy_pool (
  input  logic  clk_i,
  input  logic  rst_ni,
  spe_in_if.sink    in_i,
  spe_out_if.source out_o
);
  import spe_pkg::*;

  logic [63:0]   pool_q, pool_d;
  logic [2:0]    lane_q, lane_d;
  logic [3:0]    cnt_pend_q, cnt_pend_d;
  logic          last_pend_q, last_pend_d;
  logic          out_valid_q;
  logic [63:0]   out_word_q;
  logic [3:0]    out_cnt_q;
  logic          out_last_q;

  logic          accept;
  logic          start;
  logic          take;
  logic [63:0]   byte_mix;
  logic [63:0]   xored;
  spe_mix_stat_t mix_stat;
  logic [63:0]   mix_word;

  assign in_i.ready = !mix_stat.busy;
  assign accept     = in_i.valid && in_i.ready;

  assign byte_mix = {56'd0, in_i.value[7:0]} << {lane_q, 3'b000};

  // Pool update per item kind
  always_comb begin
    pool_d      = pool_q;
    lane_d      = lane_q;
    cnt_pend_d  = cnt_pend_q;
    last_pend_d = last_pend_q;
    start       = 1'b0;
    xored       = pool_q ^ byte_mix;
    if (accept) begin
      unique case (spe_kind_e'(in_i.kind))
        KindSeed: begin
          pool_d = in_i.value;
          lane_d = '0;
        end
        KindWord: pool_d = (pool_q ^ in_i.value) + GoldenGamma;
        KindByte: begin
          pool_d = (lane_q == LaneLast) ? xored + GoldenGamma : xored;
          lane_d = lane_q + 3'd1;
        end
        KindEnd: begin
          pool_d = pool_q + GoldenGamma;
          lane_d = '0;
        end
        KindSqueeze: begin
          pool_d      = pool_q + GoldenGamma;
          start       = 1'b1;
          cnt_pend_d  = (in_i.value > 64'(ByteMax)) ? ByteMax : in_i.value[3:0];
          last_pend_d = (in_i.value <= 64'(ByteMax));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q      <= '0;
      lane_q      <= '0;
      cnt_pend_q  <= '0;
      last_pend_q <= 1'b0;
    end else begin
      pool_q      <= pool_d;
      lane_q      <= lane_d;
      cnt_pend_q  <= cnt_pend_d;
      last_pend_q <= last_pend_d;
    end
  end

  spe_mixer u_mixer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .pool_i  (pool_d),
    .ack_i   (take),
    .stat_o  (mix_stat),
    .word_o  (mix_word)
  );

  // Output register; refilled from the mixer when empty or drained
  assign take = mix_stat.done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        out_word_q  <= mix_word;
        out_cnt_q   <= cnt_pend_q;
        out_last_q  <= last_pend_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.random_word = out_word_q;
  assign out_o.byte_count  = out_cnt_q;
  assign out_o.last        = out_last_q;

endmodule

// ===== rtl/spe_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for splitmix_entropy_pool, attached by bind.
// Depends on spe_pkg and the top level's interface ports.
module spe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [2:0]  in_kind_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  out_byte_count_i,
  input logic        out_last_i
);
  import spe_pkg::*;

  // A result item stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped before taken");

  // A squeeze item keeps the input closed while the step runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i == KindSqueeze) |=> !in_ready_i)
    else $error("input open during squeeze");

  // Other items leave the input open on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i != KindSqueeze) |=> in_ready_i)
    else $error("input closed after single-cycle item");

  // Byte count never exceeds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_byte_count_i <= ByteMax)
    else $error("byte count above word size");

  // A word that is not last is a full word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_byte_count_i == ByteMax)
    else $error("partial word without last");

endmodule

bind splitmix_entropy_pool spe_checker u_spe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_kind_i        (in_i.kind),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_byte_count_i (out_o.byte_count),
  .out_last_i       (out_o.last)
);

// ===== tb/tb_splitmix_entropy_pool.sv =====
`timescale 1ns / 1ps
// Testbench for splitmix_entropy_pool: directed and random item streams with
// random idling on both channels, checked against a built-in pool predictor.
// Depends on spe_pkg, spe_if (spe_in_if, spe_out_if) and the RTL top level.
module tb_splitmix_entropy_pool;
  import spe_pkg::*;

  // Step constants, kept apart from the package so the check is independent
  localparam logic [63:0] StepAdd  = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] StepMulA = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] StepMulB = 64'h94d0_49bb_1331_11eb;

  localparam logic [2:0]  KindSpareFirst = 3'd5;
  localparam logic [2:0]  KindSpareLast  = 3'd7;
  localparam logic [2:0]  LaneTop        = 3'd7;
  localparam logic [63:0] WordBytes      = 64'd8;
  localparam logic [3:0]  ByteCap        = 4'd8;

  localparam int RandomItems  = 1250;
  localparam int MaxIdle      = 16;
  localparam int SettleCycles = 16;
  localparam int HoldStart    = 420;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 400000;
  localparam int PrintCap     = 50;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] value;
    int unsigned gap;
    bit          drain;  // hold off until every result is back
  } pool_item_t;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
  } squeeze_res_t;

  logic clk_i;
  logic rst_ni;

  spe_in_if  in_if ();
  spe_out_if out_if ();

  splitmix_entropy_pool dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  pool_item_t   pending_items[$];
  squeeze_res_t expected_words[$];
  pool_item_t   cur_item;
  bit           have_item;
  int unsigned  settle_count;
  int unsigned  sink_wait;
  bit           hold_output;

  // predictor state
  logic [63:0] pool_q;
  logic [2:0]  byte_lane_q;

  int unsigned items_sent;
  int unsigned byte_items;
  int unsigned spare_items;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // One SplitMix64 step on the predicted pool
  function automatic logic [63:0] advance_pool();
    logic [63:0] z;
    pool_q = pool_q + StepAdd;
    z = pool_q;
    z = (z ^ (z >> 30)) * StepMulA;
    z = (z ^ (z >> 27)) * StepMulB;
    return z ^ (z >> 31);
  endfunction

  // Update the predicted pool for an accepted item; queue squeeze results
  function automatic void predict_item(logic [2:0] kind, logic [63:0] value);
    squeeze_res_t res;
    case (kind)
      KindSeed: begin
        pool_q = value;
        byte_lane_q = '0;
      end
      KindWord: begin
        pool_q ^= value;
        void'(advance_pool());
      end
      KindByte: begin
        byte_items++;
        pool_q ^= {56'd0, value[7:0]} << (8 * byte_lane_q);
        if (byte_lane_q == LaneTop) void'(advance_pool());
        byte_lane_q = byte_lane_q + 3'd1;
      end
      KindEnd: begin
        void'(advance_pool());
        byte_lane_q = '0;
      end
      KindSqueeze: begin
        res.word  = advance_pool();
        res.count = (value > WordBytes) ? ByteCap : value[3:0];
        res.last  = (value <= WordBytes);
        expected_words.push_back(res);
      end
      default: spare_items++;
    endcase
  endfunction

  // Queue an item; gaps follow the item's position in the stream
  function automatic void add_item(logic [2:0] kind, logic [63:0] value);
    pool_item_t it;
    int unsigned n;
    n = pending_items.size();
    it.kind  = kind;
    it.value = value;
    it.drain = 0;
    if (n >= 380 && n < 560) begin
      it.gap = 0;  // back-to-back while the output is held off
    end else begin
      it.gap   = ((n / 50) % 4 == 1) ? 0 : $urandom_range(0, MaxIdle);
      it.drain = (n % 170 == 169);
    end
    pending_items.push_back(it);
  endfunction

  // Well-formed use: optional seed, words, byte string, then a squeeze run
  function automatic void add_session();
    logic [63:0] want;
    int unsigned nbytes;
    if ($urandom_range(0, 2) == 0) add_item(KindSeed, rand_word());
    repeat ($urandom_range(0, 3)) add_item(KindWord, rand_word());
    nbytes = $urandom_range(0, 20);
    repeat (nbytes) add_item(KindByte, rand_word());
    // now and then the byte string is left open
    if ($urandom_range(0, 7) != 0) add_item(KindEnd, rand_word());
    want = ($urandom_range(0, 15) == 0) ? rand_word() : 64'($urandom_range(0, 40));
    for (int k = 0; k < 8; k++) begin
      add_item(KindSqueeze, want);
      if (want <= WordBytes || $urandom_range(0, 19) == 0) break;
      want -= WordBytes;
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PrintCap)
      $display("mismatch on result %0d: %s got %h expected %h",
               results_checked, what, got, want);
  endtask

  // Clock and known input levels from time zero
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KindSeed;
    in_if.value = '0;
    out_if.ready = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Single reset at the start of the run
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Driver: offers queued items, predicting each one as it is accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_item(in_if.kind, in_if.value);
        items_sent++;
        have_item = 0;
      end
      if (!have_item && pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        have_item = 1;
        settle_count = 0;
      end
      if (have_item && cur_item.drain) begin
        if (expected_words.size() != 0) settle_count = 0;
        else if (settle_count < SettleCycles) settle_count++;
        else cur_item.drain = 0;
      end else if (have_item && cur_item.gap != 0) begin
        cur_item.gap--;
      end
      in_if.valid <= have_item && !cur_item.drain && cur_item.gap == 0;
      if (have_item) begin
        in_if.kind  <= cur_item.kind;
        in_if.value <= cur_item.value;
      end
    end
  end

  // Monitor: checks each squeeze result against the oldest prediction
  always @(posedge clk_i) begin
    squeeze_res_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_checked++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected random_word", out_if.random_word, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_if.random_word !== want.word)
            report_mismatch("random_word", out_if.random_word, want.word);
          if (out_if.byte_count !== want.count)
            report_mismatch("byte_count", 64'(out_if.byte_count), 64'(want.count));
          if (out_if.last !== want.last)
            report_mismatch("last", 64'(out_if.last), 64'(want.last));
        end
        // calm stretches alternate with random stalls
        sink_wait = ((results_checked / 40) % 3 == 0) ? 0 : $urandom_range(0, MaxIdle);
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_if.ready <= (sink_wait == 0) && !hold_output;
    end
  end

  // Long output hold-off while the sender keeps going
  initial begin
    hold_output = 1'b0;
    while (items_sent < HoldStart) @(posedge clk_i);
    hold_output <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_output <= 1'b0;
  end

  // Stimulus and end of run
  initial begin
    pool_q = '0;
    byte_lane_q = '0;

    // directed: zero remaining, length boundaries, extreme words
    add_item(KindSeed, '0);
    add_item(KindSqueeze, '0);
    add_item(KindSqueeze, WordBytes);
    add_item(KindSqueeze, WordBytes + 64'd1);
    add_item(KindSqueeze, '1);
    add_item(KindSeed, '1);
    add_item(KindWord, '1);
    add_item(KindWord, '0);
    add_item(KindSqueeze, 64'd5);
    // empty byte string still steps
    add_item(KindEnd, '0);
    add_item(KindSqueeze, 64'd3);
    // nine bytes: lane wraps past 7, low value byte all set and all clear
    for (int b = 0; b < 9; b++)
      add_item(KindByte, b[0] ? (rand_word() | 64'hff) : (rand_word() & ~64'hff));
    add_item(KindEnd, '1);
    add_item(KindSqueeze, 64'd16);
    // unused kind codes are ignored
    for (logic [3:0] k = 4'(KindSpareFirst); k <= 4'(KindSpareLast); k++)
      add_item(k[2:0], rand_word());
    add_item(KindSqueeze, 64'd7);

    // random: mostly well-formed sessions, some noise
    while (pending_items.size() < RandomItems) begin
      if ($urandom_range(0, 9) < 8) add_session();
      else repeat ($urandom_range(1, 4)) add_item(3'($urandom_range(0, 7)), rand_word());
    end

    while (!(pending_items.size() == 0 && !have_item && !in_if.valid &&
             expected_words.size() == 0))
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("ran %0d items (%0d byte mixes, %0d unused kinds) and checked %0d words,",
             items_sent, byte_items, spare_items, results_checked);
    $display("with random idling, one %0d-cycle output hold-off and drain pauses",
             HoldCycles);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
